// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the allocator module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define BPA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("allocator assertion failed");

// A consequence that must hold whenever its antecedent does.
`define BPA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

`else

`define BPA_ASSERT(lbl, clk, rst_n, prop)
`define BPA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/bpa_pkg.sv =====
package bpa_pkg;

    localparam int NUM_PAGES  = 16384;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int MAP_WORDS  = NUM_PAGES / WORD_BITS;
    localparam int WORD_AW    = $clog2(MAP_WORDS);
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int CNT_W      = 15;
    localparam int KB_W       = 17;
    localparam int ADDR_W     = 32;
    localparam int OUT_ADDR_W = 26;

    // The low 2 MB are reserved at init.
    localparam int LOW_PAGES  = 32'h0020_0000 / PAGE_BYTES;
    localparam int LOW_WORDS  = LOW_PAGES / WORD_BITS;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_INIT  = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STS_OK           = 2'd0,
        STS_OUT_OF_MEM   = 2'd1,
        STS_OUT_OF_RANGE = 2'd2,
        STS_ALREADY_FREE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_FREE
    } t_state;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } t_find;

endpackage

// ===== hdl/bitmap_page_allocator.sv =====
// Bitmap first-fit page allocator, one used/free bit per 4 KB page in a 512 x 32 RAM.
// Requests: free reads the page's map word and clears its bit (no RAM access when out of
// range), type 3 does nothing, init writes one RAM word per cycle over the whole map, and
// alloc reads map words from the hint on until a free bit turns up. The strobe is registered.
// One request is in flight at a time; a new one may start during the result strobe.
// Reset is synchronous; the map is undefined until the first init, and no page is usable before it.
module bitmap_page_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_req_type,
    input  logic [bpa_pkg::ADDR_W-1:0]    i_free_address,
    input  logic                          i_cfg_we,
    input  logic [bpa_pkg::KB_W-1:0]      i_cfg_wdata,
    output logic                          o_strobe,
    output logic [bpa_pkg::OUT_ADDR_W-1:0] o_page_address,
    output logic [1:0]                    o_status,
    output logic [bpa_pkg::CNT_W-1:0]     o_free_count
);
    import bpa_pkg::*;
    `include "assert_macros.svh"

    t_state                r_state, n_state;
    logic [KB_W-1:0]       r_mem_kb;
    logic [CNT_W-1:0]      r_page_total, n_page_total;
    logic [CNT_W-1:0]      r_free_total, n_free_total;
    logic [WORD_AW-1:0]    r_hint, n_hint;
    logic [WORD_AW:0]      r_word, n_word;
    logic                  r_chk_vld, n_chk_vld;
    logic [WORD_AW-1:0]    r_chk_word, n_chk_word;
    logic [PAGE_W-1:0]     r_page, n_page;
    logic                  r_strobe, n_strobe;
    logic [OUT_ADDR_W-1:0] r_page_addr, n_page_addr;
    t_status               r_status, n_status;

    logic                  ram_we, ram_re;
    logic [WORD_AW-1:0]    ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;

    logic                  accept;
    t_req                  req;
    logic [ADDR_W-PAGE_SHIFT-1:0] free_page;
    logic                  free_in_range;
    logic [CNT_W-1:0]      kb_pages, init_total;
    logic [CNT_W:0]        limit_sum;
    logic [WORD_AW:0]      scan_limit;
    logic [CNT_W-1:0]      pages_left;
    logic                  issue;
    t_find                 fnd;
    logic [WORD_BITS-1:0]  page_bit;

    assign busy      = (r_state != ST_IDLE);
    assign accept    = start && !busy;
    assign req       = t_req'(i_req_type);
    assign free_page = i_free_address[ADDR_W-1:PAGE_SHIFT];
    assign free_in_range = (free_page < (ADDR_W - PAGE_SHIFT)'(r_page_total));

    // One page per 4 KB of installed memory, saturated at the map size.
    assign kb_pages   = r_mem_kb[KB_W-1:2];
    assign init_total = (kb_pages > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : kb_pages;

    // Number of map words that hold real pages.
    assign limit_sum  = {1'b0, r_page_total} + (CNT_W + 1)'(WORD_BITS - 1);
    assign scan_limit = limit_sum[BIT_W +: WORD_AW + 1];
    assign pages_left = r_page_total - CNT_W'({r_chk_word, {BIT_W{1'b0}}});

    // Reads are pipelined one word ahead; stop issuing once a free bit turns up.
    assign issue = (r_state == ST_SCAN) && (r_word < scan_limit)
                   && !(r_chk_vld && fnd.found);

    assign page_bit = WORD_BITS'(1) << r_page[BIT_W-1:0];

    bpa_find_free u_find (
        .i_word       (ram_rdata),
        .i_pages_left (pages_left),
        .o_find       (fnd)
    );

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (req)
                        REQ_ALLOC: n_state = ST_SCAN;
                        REQ_FREE:  n_state = free_in_range ? ST_FREE : ST_IDLE;
                        REQ_INIT:  n_state = ST_INIT;
                        REQ_NOP:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_INIT: begin
                if (r_word == (WORD_AW + 1)'(MAP_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if ((r_chk_vld && fnd.found) || (!r_chk_vld && !issue)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FREE: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_page_total = r_page_total;
        n_free_total = r_free_total;
        n_hint       = r_hint;
        n_word       = r_word;
        n_chk_vld    = 1'b0;
        n_chk_word   = r_chk_word;
        n_page       = r_page;
        n_strobe     = 1'b0;
        n_page_addr  = '0;
        n_status     = STS_OK;
        ram_we       = 1'b0;
        ram_waddr    = r_chk_word;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = r_word[WORD_AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (req)
                        REQ_ALLOC: begin
                            n_word = {1'b0, r_hint};
                        end
                        REQ_FREE: begin
                            n_page = free_page[PAGE_W-1:0];
                            if (free_in_range) begin
                                ram_re    = 1'b1;
                                ram_raddr = free_page[PAGE_W-1:BIT_W];
                            end else begin
                                n_strobe = 1'b1;
                                n_status = STS_OUT_OF_RANGE;
                            end
                        end
                        REQ_INIT: begin
                            n_page_total = init_total;
                            n_free_total = (init_total > CNT_W'(LOW_PAGES))
                                           ? init_total - CNT_W'(LOW_PAGES) : '0;
                            n_word       = '0;
                            n_hint       = WORD_AW'(LOW_WORDS);
                        end
                        REQ_NOP: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_word[WORD_AW-1:0];
                ram_wdata = (r_word < (WORD_AW + 1)'(LOW_WORDS)) ? '1 : '0;
                n_word    = r_word + 1'b1;
                if (r_word == (WORD_AW + 1)'(MAP_WORDS - 1)) begin
                    n_strobe = 1'b1;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    ram_re = 1'b1;
                    n_word = r_word + 1'b1;
                end
                n_chk_vld  = issue;
                n_chk_word = r_word[WORD_AW-1:0];
                if (r_chk_vld && fnd.found) begin
                    ram_we      = 1'b1;
                    ram_waddr   = r_chk_word;
                    ram_wdata   = ram_rdata | (WORD_BITS'(1) << fnd.idx);
                    n_hint      = r_chk_word;
                    n_free_total = (r_free_total != '0) ? r_free_total - 1'b1 : r_free_total;
                    n_strobe    = 1'b1;
                    n_page_addr = {r_chk_word, fnd.idx, {PAGE_SHIFT{1'b0}}};
                end else if (!r_chk_vld && !issue) begin
                    n_strobe = 1'b1;
                    n_status = STS_OUT_OF_MEM;
                end
            end
            ST_FREE: begin
                n_strobe = 1'b1;
                if ((ram_rdata & page_bit) == '0) begin
                    n_status = STS_ALREADY_FREE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_page[PAGE_W-1:BIT_W];
                    ram_wdata = ram_rdata & ~page_bit;
                    if (r_free_total < r_page_total) begin
                        n_free_total = r_free_total + 1'b1;
                    end
                    if (r_page[PAGE_W-1:BIT_W] < r_hint) begin
                        n_hint = r_page[PAGE_W-1:BIT_W];
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mem_kb     <= '0;
            r_page_total <= '0;
            r_free_total <= '0;
            r_hint       <= '0;
            r_word       <= '0;
            r_chk_vld    <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_we) begin
                r_mem_kb <= i_cfg_wdata;
            end
            r_page_total <= n_page_total;
            r_free_total <= n_free_total;
            r_hint       <= n_hint;
            r_word       <= n_word;
            r_chk_vld    <= n_chk_vld;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_word  <= n_chk_word;
        r_page      <= n_page;
        r_page_addr <= n_page_addr;
        r_status    <= n_status;
    end

    assign o_strobe       = r_strobe;
    assign o_page_address = r_page_addr;
    assign o_status       = r_status;
    assign o_free_count   = r_free_total;

    `BPA_ASSERT(a_free_le_total, i_clk, i_rst_n, r_free_total <= r_page_total)
    `BPA_ASSERT_IMPL(a_chk_in_map, i_clk, i_rst_n, r_chk_vld, (WORD_AW + 1)'(r_chk_word) < scan_limit)
    `BPA_ASSERT_IMPL(a_oom_addr_zero, i_clk, i_rst_n, r_strobe && (r_status != STS_OK), r_page_addr == '0)
    `BPA_ASSERT_IMPL(a_no_rw_clash, i_clk, i_rst_n, ram_we && ram_re, ram_waddr != ram_raddr)

endmodule

// ===== hdl/bpa_ram.sv =====
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bpa_find_free.sv =====
module bpa_find_free (
    input  logic [bpa_pkg::WORD_BITS-1:0] i_word,
    input  logic [bpa_pkg::CNT_W-1:0]     i_pages_left,
    output bpa_pkg::t_find                o_find
);
    import bpa_pkg::*;

    logic [WORD_BITS-1:0] limit_mask;
    logic [WORD_BITS-1:0] free_bits;

    // Bits at or above the page count are not real pages and never count as free.
    always_comb begin
        if (i_pages_left >= CNT_W'(WORD_BITS)) begin
            limit_mask = '1;
        end else begin
            limit_mask = (WORD_BITS'(1) << i_pages_left[BIT_W-1:0]) - WORD_BITS'(1);
        end
        free_bits = ~i_word & limit_mask;
    end

    always_comb begin
        o_find.found = |free_bits;
        o_find.idx   = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                o_find.idx = BIT_W'(b);
            end
        end
    end

endmodule

// ===== dv/bitmap_page_allocator_tb.sv =====
module bitmap_page_allocator_tb;
    import bpa_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] page_addr;
        t_status               status;
        logic [CNT_W-1:0]      free_count;
    } t_grant;

    // Tracks the page map as the block should hold it and the results it owes.
    class t_page_ledger;
        bit [WORD_BITS-1:0] used_map [MAP_WORDS];
        int unsigned        size_kb;
        int unsigned        page_total;
        int unsigned        free_total;
        int                 errors;
        t_grant             owed_q[$];

        function new();
            size_kb    = 0;
            page_total = 0;
            free_total = 0;
            errors     = 0;
            foreach (used_map[w]) used_map[w] = '0;
        endfunction

        function bit is_used(int unsigned page);
            return used_map[page / WORD_BITS][page % WORD_BITS];
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Tries a few random pages below the page count and prefers one in use.
        function int unsigned pick_used_page();
            int unsigned page;
            page = 0;
            if (page_total == 0) return 0;
            repeat (16) begin
                page = $urandom_range(page_total - 1, 0);
                if (is_used(page)) return page;
            end
            return page;
        endfunction

        function void note_request(t_req req, logic [ADDR_W-1:0] addr);
            t_grant      g;
            int unsigned page;
            int unsigned w;
            int unsigned b;
            bit          found;
            g        = '0;
            g.status = STS_OK;
            found    = 0;
            page     = 0;
            case (req)
                REQ_INIT: begin
                    page_total = (size_kb * 1024) / PAGE_BYTES;
                    if (page_total > NUM_PAGES) page_total = NUM_PAGES;
                    foreach (used_map[i]) used_map[i] = '0;
                    for (w = 0; w < LOW_WORDS; w++) used_map[w] = '1;
                    free_total = (page_total > LOW_PAGES) ? page_total - LOW_PAGES : 0;
                end
                REQ_ALLOC: begin
                    // The lowest free page overall; it only counts below the page count.
                    for (w = 0; w < MAP_WORDS && !found; w++) begin
                        if (used_map[w] != '1) begin
                            for (b = 0; b < WORD_BITS && !found; b++) begin
                                if (!used_map[w][b]) begin
                                    page  = w * WORD_BITS + b;
                                    found = 1;
                                end
                            end
                        end
                    end
                    if (found && page < page_total) begin
                        used_map[page / WORD_BITS][page % WORD_BITS] = 1'b1;
                        if (free_total > 0) free_total--;
                        g.page_addr = OUT_ADDR_W'(page * PAGE_BYTES);
                    end else begin
                        g.status = STS_OUT_OF_MEM;
                    end
                end
                REQ_FREE: begin
                    page = addr >> PAGE_SHIFT;
                    if (page >= page_total) begin
                        g.status = STS_OUT_OF_RANGE;
                    end else if (!is_used(page)) begin
                        g.status = STS_ALREADY_FREE;
                    end else begin
                        used_map[page / WORD_BITS][page % WORD_BITS] = 1'b0;
                        if (free_total < page_total) free_total++;
                    end
                end
                default: begin
                end
            endcase
            g.free_count = free_total[CNT_W-1:0];
            owed_q.push_back(g);
        endfunction

        function bit field_bad(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                return 1;
            end
            return 0;
        endfunction

        function void check_result(logic [OUT_ADDR_W-1:0] addr, logic [1:0] status,
                                   logic [CNT_W-1:0] count);
            t_grant want;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual addr %0h status %0d count %0d",
                         $time, addr, status, count);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            errors += field_bad("page_address", 32'(want.page_addr), 32'(addr));
            errors += field_bad("status", 32'(want.status), 32'(status));
            errors += field_bad("free_count", 32'(want.free_count), 32'(count));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            i_req_type;
    logic [ADDR_W-1:0]     i_free_address;
    logic                  i_cfg_we;
    logic [KB_W-1:0]       i_cfg_wdata;
    logic                  o_strobe;
    logic [OUT_ADDR_W-1:0] o_page_address;
    logic [1:0]            o_status;
    logic [CNT_W-1:0]      o_free_count;

    t_page_ledger ledger = new();
    int           cycles = 0;

    bitmap_page_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_free_address (i_free_address),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_page_address (o_page_address),
        .o_status       (o_status),
        .o_free_count   (o_free_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("bitmap_page_allocator test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            ledger.check_result(o_page_address, o_status, o_free_count);
    end

    // Holds the request until the block takes it.
    task automatic issue(t_req req, logic [ADDR_W-1:0] addr);
        @(negedge i_clk);
        start          = 1'b1;
        i_req_type     = req;
        i_free_address = addr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        ledger.note_request(req, addr);
    endtask

    task automatic idle(int n);
        repeat (n) begin
            @(negedge i_clk);
            start          = 1'b0;
            i_req_type     = 2'($urandom);
            i_free_address = $urandom;
        end
    endtask

    task automatic wait_results();
        idle(1);
        while (ledger.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_size(int unsigned kb);
        wait_results();
        @(negedge i_clk);
        i_cfg_we       = 1'b1;
        i_cfg_wdata    = KB_W'(kb);
        ledger.size_kb = kb;
        @(negedge i_clk);
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = KB_W'($urandom);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] page_to_addr(int unsigned page);
        return ADDR_W'(page * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
    endfunction

    task automatic run_phase(int unsigned kb, int n);
        int          r;
        bit          calm;
        int unsigned edge_page;
        write_size(kb);
        issue(REQ_INIT, $urandom);
        calm = ($urandom_range(0, 3) == 0);
        repeat (n) begin
            r = $urandom_range(0, 99);
            edge_page = (ledger.page_total == 0) ? 0 : ledger.page_total - 1;
            if (r < 40) begin
                issue(REQ_ALLOC, $urandom);
            end else if (r < 70) begin
                issue(REQ_FREE, page_to_addr(ledger.pick_used_page()));
            end else if (r < 78) begin
                issue(REQ_FREE, page_to_addr($urandom_range(edge_page, 0)));
            end else if (r < 86) begin
                issue(REQ_FREE, $urandom);
            end else if (r < 89) begin
                // Last page in range or the first one past it.
                issue(REQ_FREE, page_to_addr(edge_page + $urandom_range(0, 1)));
            end else if (r < 92) begin
                issue(REQ_NOP, $urandom);
            end else if (r < 94) begin
                issue(REQ_INIT, $urandom);
            end else if (r < 96) begin
                wait_results();
                issue(REQ_ALLOC, $urandom);
            end else begin
                issue(REQ_ALLOC, $urandom);
            end
            if (!calm) idle(gap_len());
        end
    endtask

    initial begin
        int unsigned kb;
        start          = 1'b0;
        i_rst_n        = 1'b0;
        i_req_type     = REQ_ALLOC;
        i_free_address = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Nothing is usable before the first init.
        issue(REQ_ALLOC, '0);
        issue(REQ_FREE, '0);
        issue(REQ_NOP, '1);

        write_size(0);
        issue(REQ_INIT, '0);
        issue(REQ_ALLOC, '0);

        // Memory below 2 MB: reserved pages can be freed and handed out again.
        write_size(2000);
        issue(REQ_INIT, '0);
        issue(REQ_FREE, 32'h0000_0000);
        issue(REQ_ALLOC, '0);
        issue(REQ_ALLOC, '0);

        // Size past the map saturates the page count.
        write_size(131071);
        issue(REQ_INIT, '1);
        issue(REQ_ALLOC, '0);
        issue(REQ_FREE, 32'hFFFF_FFFF);
        issue(REQ_FREE, (NUM_PAGES - 1) * PAGE_BYTES + 32'hFFF);
        issue(REQ_ALLOC, '0);
        issue(REQ_FREE, 32'h0020_0000);
        issue(REQ_FREE, 32'h0020_0000);
        issue(REQ_NOP, '0);

        write_size(65536);
        issue(REQ_INIT, '0);
        issue(REQ_ALLOC, '0);

        // One free page above the reserved region.
        write_size(2052);
        issue(REQ_INIT, '0);
        issue(REQ_ALLOC, '0);
        issue(REQ_ALLOC, '0);
        issue(REQ_FREE, 513 * PAGE_BYTES);
        issue(REQ_FREE, 512 * PAGE_BYTES + 32'h123);

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: kb = 131071;
                1: kb = 65536;
                2: kb = $urandom_range(0, 2047);
                3: kb = $urandom_range(0, 131071);
                default: kb = $urandom_range(2048 + 32, 2048 + 480);
            endcase
            run_phase(kb, 188);
        end

        wait_results();
        repeat (20) @(posedge i_clk);
        if (ledger.errors == 0)
            $display("bitmap_page_allocator test passed");
        else
            $display("bitmap_page_allocator test failed");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bpa_pkg.sv
hdl/bpa_ram.sv
hdl/bpa_find_free.sv
hdl/bitmap_page_allocator.sv
dv/bitmap_page_allocator_tb.sv
